@@ hw/rtl/station_presence_table_defines.svh @@
// Assertion macros for the station presence table
`ifndef STATION_PRESENCE_TABLE_DEFINES_SVH
`define STATION_PRESENCE_TABLE_DEFINES_SVH
`ifndef SYNTH
`define SPT_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SPT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SPT_ASSERT_IMPL(label, clk, rst_n, a, c)
`define SPT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ hw/rtl/spt_pkg.sv @@
package spt_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LEAVES = 1 << IDX_W;

    localparam logic [1:0] EV_TRACKED = 2'd0;
    localparam logic [1:0] EV_FULL    = 2'd1;
    localparam logic [1:0] EV_OFFLINE = 2'd2;
    localparam logic [1:0] EV_SUMMARY = 2'd3;

    localparam logic KIND_OBSERVE = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request fields
        logic scan;      // compare all entries
        logic commit;    // write back observed station
        logic sweep;     // handle entry at sweep pointer
        logic summary;   // summary result and clear seen map
        logic sweep_clr; // reset sweep pointer
    } spt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;      // miss and nothing to evict
        logic sweep_hit; // current sweep entry goes offline
        logic sweep_end; // sweep pointer at last entry
    } spt_stat_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  entry_index;
        logic        new_entry;
        logic        became_online;
        logic        lease_changed;
        logic [47:0] entry_mac;
        logic [31:0] entry_ipv4;
        logic [31:0] entry_connects;
        logic [4:0]  online_total;
        logic [4:0]  known_total;
        logic        last;
    } spt_res_t;

    typedef struct packed {
        logic        kind;
        logic [47:0] station_mac;
        logic [31:0] lease_ipv4;
        logic [31:0] now_ms;
    } spt_req_t;
endpackage

@@ hw/rtl/spt_if.sv @@
interface spt_req_if;
    import spt_pkg::*;
    logic     valid;
    logic     ready;
    spt_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spt_res_if;
    import spt_pkg::*;
    logic     valid;
    logic     ready;
    spt_res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spt_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/station_presence_table.sv @@
// Observe request: lookup (S_SCAN), then write back (S_COMMIT), which registers the result.
// End of scan: each entry is swept in turn (one result per entry that goes offline), then
// the summary; each stalled result holds the sweep in place.
// Next request taken the cycle after the last result leaves; requests do not overlap.
// Reset (rst_n low, asynchronous) clears valid, online and seen bits and the enable.
module station_presence_table (
    input logic   clk,
    input logic   rst_n,
    spt_req_if.sink   req,
    spt_res_if.source res,
    spt_cfg_if.sink   cfg
);
    import spt_pkg::*;

    spt_cmd_t  cmd;
    spt_stat_t stat;
    logic      enable_reg;

    // enable register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else if (cfg.valid)
            enable_reg <= cfg.data;
    end

    spt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable_reg),
        .in_valid  (req.valid),
        .in_kind   (req.data.kind),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spt_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req.data),
        .stat  (stat),
        .res   (res.data)
    );
endmodule

@@ hw/rtl/spt_datapath.sv @@
module spt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  spt_pkg::spt_cmd_t  cmd,
    input  spt_pkg::spt_req_t  req,
    output spt_pkg::spt_stat_t stat,
    output spt_pkg::spt_res_t  res
);
    import spt_pkg::*;

    logic [ENTRIES-1:0] valid_reg, online_reg, seen_reg;
    logic [47:0] addr_reg [ENTRIES];
    logic [31:0] lease_reg [ENTRIES];
    logic [31:0] last_reg [ENTRIES];
    logic [31:0] conn_reg [ENTRIES];

    spt_req_t   q_reg;
    spt_res_t   res_reg, res_next;
    logic       hit_reg, free_reg, evict_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg, evict_idx_reg;
    logic [IDX_W-1:0] ptr_reg;

    // parallel lookup: match and lowest free
    logic       hit_c, free_c, ev_c;
    logic [IDX_W-1:0] hit_i, free_i, ev_i;
    always_comb
    begin
        hit_c = 1'b0; free_c = 1'b0;
        hit_i = '0; free_i = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && addr_reg[i] == q_reg.station_mac)
            begin
                hit_c = 1'b1;
                hit_i = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_c = 1'b1;
                free_i = IDX_W'(i);
            end
        end
    end

    // oldest offline entry, compare tree, ties to the higher index
    logic             t_ok   [2*LEAVES];
    logic [31:0]      t_last [2*LEAVES];
    logic [IDX_W-1:0] t_idx  [2*LEAVES];
    always_comb
    begin
        for (int n = 0; n < 2*LEAVES; n++)
        begin
            t_ok[n] = 1'b0;
            t_last[n] = '0;
            t_idx[n] = '0;
        end
        for (int i = 0; i < LEAVES; i++)
        begin
            t_idx[LEAVES + i] = IDX_W'(i);
            if (i < ENTRIES)
            begin
                t_ok[LEAVES + i] = !online_reg[i];
                t_last[LEAVES + i] = last_reg[i];
            end
        end
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            if (t_ok[2*n+1] && (!t_ok[2*n] || t_last[2*n+1] <= t_last[2*n]))
            begin
                t_ok[n] = 1'b1;
                t_last[n] = t_last[2*n+1];
                t_idx[n] = t_idx[2*n+1];
            end
            else
            begin
                t_ok[n] = t_ok[2*n];
                t_last[n] = t_last[2*n];
                t_idx[n] = t_idx[2*n];
            end
        end
        ev_c = t_ok[1];
        ev_i = t_idx[1];
    end

    // resolved slot for write back
    logic [IDX_W-1:0] slot;
    logic fresh, was_on, lchg;
    logic [31:0] old_lease, old_conn, new_lease, new_conn;
    always_comb
    begin
        fresh = !hit_reg;
        slot = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : evict_idx_reg);
        was_on = hit_reg ? online_reg[slot] : 1'b0;
        old_lease = hit_reg ? lease_reg[slot] : 32'd0;
        old_conn = hit_reg ? conn_reg[slot] : 32'd0;
        new_conn = was_on ? old_conn : old_conn + 32'd1;
        lchg = (q_reg.lease_ipv4 != 32'd0) && (q_reg.lease_ipv4 != old_lease);
        new_lease = lchg ? q_reg.lease_ipv4 : old_lease;
    end

    logic [CNT_W-1:0] on_cnt, kn_cnt;
    always_comb
    begin
        on_cnt = '0; kn_cnt = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            kn_cnt = kn_cnt + CNT_W'(valid_reg[i]);
            on_cnt = on_cnt + CNT_W'(valid_reg[i] & online_reg[i]);
        end
    end

    assign stat.full = !hit_reg && !free_reg && !evict_reg;
    assign stat.sweep_hit = valid_reg[ptr_reg] && online_reg[ptr_reg] && !seen_reg[ptr_reg];
    assign stat.sweep_end = (ptr_reg == IDX_W'(ENTRIES - 1));

    // control state of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            online_reg <= '0;
            seen_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            if (cmd.sweep_clr)
                ptr_reg <= '0;
            else if (cmd.sweep)
                ptr_reg <= ptr_reg + IDX_W'(1);
            if (cmd.commit && !stat.full)
            begin
                valid_reg[slot] <= 1'b1;
                online_reg[slot] <= 1'b1;
                seen_reg[slot] <= 1'b1;
            end
            if (cmd.sweep && stat.sweep_hit)
                online_reg[ptr_reg] <= 1'b0;
            if (cmd.summary)
                seen_reg <= '0;
        end
    end

    // next result
    always_comb
    begin
        res_next = '0;
        if (cmd.commit)
        begin
            res_next.last = 1'b1;
            if (stat.full)
            begin
                res_next.event_res = EV_FULL;
                res_next.entry_mac = q_reg.station_mac;
            end
            else
            begin
                res_next.event_res = EV_TRACKED;
                res_next.entry_index = 4'(slot);
                res_next.new_entry = fresh;
                res_next.became_online = !was_on;
                res_next.lease_changed = lchg;
                res_next.entry_mac = q_reg.station_mac;
                res_next.entry_ipv4 = new_lease;
                res_next.entry_connects = new_conn;
            end
        end
        else if (cmd.sweep)
        begin
            res_next.event_res = EV_OFFLINE;
            res_next.entry_index = 4'(ptr_reg);
            res_next.entry_mac = addr_reg[ptr_reg];
            res_next.entry_ipv4 = lease_reg[ptr_reg];
            res_next.entry_connects = conn_reg[ptr_reg];
        end
        else if (cmd.summary)
        begin
            res_next.event_res = EV_SUMMARY;
            res_next.online_total = 5'(on_cnt);
            res_next.known_total = 5'(kn_cnt);
            res_next.last = 1'b1;
        end
    end

    assign res = res_reg;

    // payload and results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            q_reg <= req;
        if (cmd.scan)
        begin
            hit_reg <= hit_c; hit_idx_reg <= hit_i;
            free_reg <= free_c; free_idx_reg <= free_i;
            evict_reg <= ev_c; evict_idx_reg <= ev_i;
        end
        if (cmd.commit || cmd.sweep || cmd.summary)
            res_reg <= res_next;
        if (cmd.commit && !stat.full)
        begin
            addr_reg[slot] <= q_reg.station_mac;
            lease_reg[slot] <= new_lease;
            conn_reg[slot] <= new_conn;
            last_reg[slot] <= q_reg.now_ms;
        end
        if (cmd.sweep && stat.sweep_hit)
            last_reg[ptr_reg] <= q_reg.now_ms;
    end
endmodule

@@ hw/rtl/spt_ctrl.sv @@
`include "station_presence_table_defines.svh"
module spt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               in_valid,
    input  logic               in_kind,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  spt_pkg::spt_stat_t stat,
    output spt_pkg::spt_cmd_t  cmd
);
    import spt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_COMMIT, S_SWEEP, S_SUMMARY, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_valid_next;

    wire take = in_valid && in_ready;
    wire out_free = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = take;
        cmd.sweep_clr = take;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_SCAN:    cmd.scan = 1'b1;
            S_COMMIT:
            begin
                cmd.commit = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            S_SWEEP:
            begin
                cmd.sweep = out_free;
                if (out_free)
                    out_valid_next = stat.sweep_hit;
            end
            S_SUMMARY:
            begin
                cmd.summary = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:   ;
        endcase
    end

    // sequencer with result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (take && enable)
                        state_reg <= (in_kind == KIND_END) ? S_SWEEP : S_SCAN;
                end
                S_SCAN: state_reg <= S_COMMIT;
                S_COMMIT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                S_SWEEP:
                begin
                    if (out_free)
                        state_reg <= stat.sweep_end ? S_SUMMARY : S_SWEEP;
                end
                S_SUMMARY:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SPT_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `SPT_ASSERT_NEXT(a_scan_commit, clk, rst_n, state_reg == S_SCAN, state_reg == S_COMMIT)
    `SPT_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.scan, cmd.commit, cmd.sweep, cmd.summary}))
endmodule

@@ tb/sv/station_presence_table_test.sv @@
module station_presence_table_test;
    import spt_pkg::*;

    logic clk;
    logic rst_n;

    spt_req_if req_ch ();
    spt_res_if res_ch ();
    spt_cfg_if cfg_ch ();

    station_presence_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .res   (res_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // shadow copy of the table
    logic        tbl_enable;
    logic        sh_valid  [ENTRIES];
    logic        sh_online [ENTRIES];
    logic [47:0] sh_mac    [ENTRIES];
    logic [31:0] sh_lease  [ENTRIES];
    logic [31:0] sh_last   [ENTRIES];
    logic [31:0] sh_conn   [ENTRIES];
    logic        sh_seen   [ENTRIES];

    spt_res_t expected_events [$];
    int       mismatch_count;
    int       results_seen;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       recv_hold;

    // directed stimulus row; has_exp marks rows with a typed-in result
    typedef struct {
        spt_req_t req;
        bit       has_exp;
        spt_res_t exp;
    } stim_row_t;

    stim_row_t dir_rows [$];

    function automatic spt_res_t mk_res(logic [1:0] ev, logic [3:0] idx, logic nw,
                                        logic bo, logic lc, logic [47:0] mac,
                                        logic [31:0] ip, logic [31:0] cn,
                                        logic [4:0] on, logic [4:0] kn, logic lst);
        spt_res_t r;
        r.event_res = ev;
        r.entry_index = idx;
        r.new_entry = nw;
        r.became_online = bo;
        r.lease_changed = lc;
        r.entry_mac = mac;
        r.entry_ipv4 = ip;
        r.entry_connects = cn;
        r.online_total = on;
        r.known_total = kn;
        r.last = lst;
        return r;
    endfunction

    // compute the events caused by one request and update the shadow table
    task automatic predict_station_events(spt_req_t rq);
        int idx;
        int oldest;
        logic fresh;
        logic up;
        logic lchg;
        logic [4:0] on;
        logic [4:0] kn;
        logic [32:0] best;
        idx = -1;
        fresh = 0;
        up = 0;
        lchg = 0;
        on = 0;
        kn = 0;
        if (!tbl_enable)
            return;
        if (rq.kind == KIND_OBSERVE)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (idx < 0 && sh_valid[i] && sh_mac[i] == rq.station_mac)
                    idx = i;
            if (idx < 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (idx < 0 && !sh_valid[i])
                        idx = i;
                if (idx < 0)
                begin
                    oldest = -1;
                    best = 33'h1_0000_0000;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!sh_online[i] && {1'b0, sh_last[i]} <= best)
                        begin
                            best = {1'b0, sh_last[i]};
                            oldest = i;
                        end
                    idx = oldest;
                end
                if (idx < 0)
                begin
                    expected_events.push_back(mk_res(EV_FULL, 0, 0, 0, 0, rq.station_mac,
                                                     0, 0, 0, 0, 1));
                    return;
                end
                sh_valid[idx] = 1;
                sh_online[idx] = 0;
                sh_mac[idx] = rq.station_mac;
                sh_lease[idx] = 0;
                sh_conn[idx] = 0;
                fresh = 1;
            end
            sh_seen[idx] = 1;
            sh_last[idx] = rq.now_ms;
            if (!sh_online[idx])
            begin
                sh_online[idx] = 1;
                sh_conn[idx] = sh_conn[idx] + 1;
                up = 1;
            end
            if (rq.lease_ipv4 != 0 && rq.lease_ipv4 != sh_lease[idx])
            begin
                sh_lease[idx] = rq.lease_ipv4;
                lchg = 1;
            end
            expected_events.push_back(mk_res(EV_TRACKED, idx[3:0], fresh, up, lchg,
                                             sh_mac[idx], sh_lease[idx], sh_conn[idx],
                                             0, 0, 1));
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (sh_valid[i] && sh_online[i] && !sh_seen[i])
                begin
                    sh_online[i] = 0;
                    sh_last[i] = rq.now_ms;
                    expected_events.push_back(mk_res(EV_OFFLINE, i[3:0], 0, 0, 0, sh_mac[i],
                                                     sh_lease[i], sh_conn[i], 0, 0, 0));
                end
            for (int i = 0; i < ENTRIES; i++)
                if (sh_valid[i])
                begin
                    kn++;
                    if (sh_online[i])
                        on++;
                end
            expected_events.push_back(mk_res(EV_SUMMARY, 0, 0, 0, 0, 0, 0, 0, on, kn, 1));
            for (int i = 0; i < ENTRIES; i++)
                sh_seen[i] = 0;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 0;
        else
            res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        spt_res_t g;
        spt_res_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            g = res_ch.data;
            if (expected_events.size() == 0)
                report_mismatch("with nothing expected, event_res", g.event_res, 0);
            else
            begin
                w = expected_events.pop_front();
                if (g.event_res != w.event_res)
                    report_mismatch("event_res", g.event_res, w.event_res);
                if (g.entry_index != w.entry_index)
                    report_mismatch("entry_index", g.entry_index, w.entry_index);
                if (g.new_entry != w.new_entry)
                    report_mismatch("new_entry", g.new_entry, w.new_entry);
                if (g.became_online != w.became_online)
                    report_mismatch("became_online", g.became_online, w.became_online);
                if (g.lease_changed != w.lease_changed)
                    report_mismatch("lease_changed", g.lease_changed, w.lease_changed);
                if (g.entry_mac != w.entry_mac)
                    report_mismatch("entry_mac", g.entry_mac, w.entry_mac);
                if (g.entry_ipv4 != w.entry_ipv4)
                    report_mismatch("entry_ipv4", g.entry_ipv4, w.entry_ipv4);
                if (g.entry_connects != w.entry_connects)
                    report_mismatch("entry_connects", g.entry_connects, w.entry_connects);
                if (g.online_total != w.online_total)
                    report_mismatch("online_total", g.online_total, w.online_total);
                if (g.known_total != w.known_total)
                    report_mismatch("known_total", g.known_total, w.known_total);
                if (g.last != w.last) report_mismatch("last", g.last, w.last);
            end
            results_seen++;
        end
    end

    // send one request, predicting on acceptance; valid stays up until the next
    // idle cycle or until the caller drops it
    task automatic send_request(spt_req_t rq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 0;
            @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.data <= rq;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_station_events(rq);
    endtask

    // write the enable once the block is drained
    task automatic write_enable(logic v);
        req_ch.valid <= 0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        cfg_ch.valid <= 1;
        cfg_ch.data <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 0;
        tbl_enable = v;
    endtask

    function automatic spt_req_t mk_req(logic k, logic [47:0] mac, logic [31:0] ls,
                                        logic [31:0] t);
        spt_req_t r;
        r.kind = k;
        r.station_mac = mac;
        r.lease_ipv4 = ls;
        r.now_ms = t;
        return r;
    endfunction

    function automatic logic [47:0] rand_mac();
        return {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
    endfunction

    task automatic add_row(spt_req_t rq, bit he, spt_res_t ex);
        stim_row_t r;
        r.req = rq;
        r.has_exp = he;
        r.exp = ex;
        dir_rows.push_back(r);
    endtask

    // long receiver hold-off counted in cycles
    initial
    begin
        recv_hold = 0;
        wait (results_seen > 60);
        recv_hold = 1;
        repeat (400) @(posedge clk);
        recv_hold = 0;
    end

    initial
    begin
        spt_res_t none;
        logic [47:0] pool [24];
        logic [31:0] now;
        int n_items;
        int wait_cyc;
        none = '0;
        mismatch_count = 0;
        results_seen = 0;
        send_idle_pct = 31;
        recv_idle_pct = 45;
        tbl_enable = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sh_valid[i] = 0;
            sh_online[i] = 0;
            sh_seen[i] = 0;
            sh_mac[i] = 0;
            sh_lease[i] = 0;
            sh_last[i] = 0;
            sh_conn[i] = 0;
        end
        req_ch.valid = 0;
        req_ch.data = '0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // disabled: ignored
        send_request(mk_req(KIND_OBSERVE, 48'h1, 32'h1, 0));
        send_request(mk_req(KIND_END, 0, 0, 0));
        write_enable(1);

        // directed table
        add_row(mk_req(KIND_END, 0, 0, 0), 1, mk_res(EV_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(KIND_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                mk_res(EV_TRACKED, 0, 1, 1, 1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 1));
        add_row(mk_req(KIND_OBSERVE, 48'h0, 32'h0, 32'h0), 1,
                mk_res(EV_TRACKED, 1, 1, 1, 0, 0, 0, 1, 0, 0, 1));
        add_row(mk_req(KIND_OBSERVE, 48'h0, 32'h0A00_0001, 32'h5), 0, none);
        add_row(mk_req(KIND_OBSERVE, 48'h0, 32'h0A00_0001, 32'h6), 0, none);
        add_row(mk_req(KIND_END, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h10), 0, none);
        add_row(mk_req(KIND_OBSERVE, 48'h0, 32'h0, 32'h20), 0, none);
        add_row(mk_req(KIND_END, 0, 0, 32'h30), 0, none);
        for (int i = 0; i < 15; i++)
            add_row(mk_req(KIND_OBSERVE, 48'hA0_0000 + i, i, 32'h40 + i), 0, none);
        add_row(mk_req(KIND_OBSERVE, 48'h5555_5555_5555, 0, 32'h50), 1,
                mk_res(EV_FULL, 0, 0, 0, 0, 48'h5555_5555_5555, 0, 0, 0, 0, 1));
        add_row(mk_req(KIND_END, 0, 0, 32'h60), 0, none);
        foreach (dir_rows[k])
        begin
            send_request(dir_rows[k].req);
            if (dir_rows[k].has_exp && expected_events[$] != dir_rows[k].exp)
                report_mismatch("directed row predicted, row", k, 0);
        end

        // random: scans over a pool of stations, with noise
        for (int i = 0; i < 24; i++)
            pool[i] = rand_mac();
        now = $urandom();
        n_items = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 31;
                write_enable(0);
                send_request(mk_req(KIND_OBSERVE, rand_mac(), $urandom(), now));
                write_enable(1);
            end
            if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (n_items < 45 * (ph + 1))
            begin
                now = now + $urandom_range(2000);
                if ($urandom_range(99) < 12)
                    send_request(mk_req(KIND_END, rand_mac(), $urandom(), now));
                else if ($urandom_range(99) < 10)
                    send_request(mk_req(KIND_OBSERVE, rand_mac(), $urandom(), now));
                else
                    send_request(mk_req(KIND_OBSERVE, pool[$urandom_range(23)],
                                        ($urandom_range(3) == 0) ? 32'h0 :
                                        32'h0A00_0000 + $urandom_range(3), now));
                n_items++;
            end
        end
        send_request(mk_req(KIND_END, 0, 0, now + 1));
        req_ch.valid <= 0;

        wait_cyc = 0;
        while (expected_events.size() != 0 && wait_cyc < 200000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (40) @(posedge clk);
        $display("Covered %0d random requests plus directed table, %0d results checked",
                 n_items, results_seen);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
